@@ src/s2d_pkg.sv @@
// ----------------------------------------------------------------------------
// s2d_pkg
// Types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package s2d_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned DIG_W      = 4;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = NUM_DIGITS * DIG_W;
	localparam int unsigned IDX_W      = $clog2(NUM_DIGITS + 1);
	localparam int unsigned STEPS      = 4;
	localparam int unsigned CONV_CYCLES = VAL_W / STEPS;
	localparam int unsigned CNT_W      = $clog2(CONV_CYCLES);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [VAL_W-1:0] bin;
	} dbl_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_COUNT = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

endpackage

@@ src/s2d_if.sv @@
// ----------------------------------------------------------------------------
// s2d_if
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface s2d_in_if;
	import s2d_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if;
	import s2d_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  ascii_char;
	logic               last_char;
	logic [COUNT_W-1:0] char_count;

	modport source (output valid, output ascii_char, output last_char, output char_count,
		input ready);
	modport sink   (input valid, input ascii_char, input last_char, input char_count,
		output ready);
endinterface

@@ src/signed_int_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer to decimal ascii, one character per beat.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | beats per number
//  num     | in  | value[31:0] signed                   | 1
//  text    | out | ascii_char[7:0] last_char char_count | 1 to 11
//
//  each number is accepted, converted by 8 passes of the shared shift-add-3 unit
//  at 4 bits each, and its digits are counted; then one character per cycle
//  goes out while text does not stall
//  text stalls hold the sequencer; num is ready only between numbers
//  the last character sits in the output register while the next number enters
//  reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
	import s2d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	s2d_in_if.sink    num,
	s2d_out_if.source text
);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [IDX_W-1:0]   ndig_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] total_q;
	dbl_t               dbl_q;
	dbl_t               dbl_nxt;

	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               slot_free;
	logic               load;
	logic [CHAR_W-1:0]  load_char;
	logic               load_last;
	logic [VAL_W-1:0]   mag;
	logic [IDX_W-1:0]   ndig_c;
	logic [DIG_W-1:0]   digs [NUM_DIGITS];

	s2d_dabble u_dabble (
		.cur (dbl_q),
		.nxt (dbl_nxt)
	);

	assign num.ready = (state_q == ST_IDLE);
	assign accept    = num.valid && num.ready;
	assign mag       = num.value[VAL_W-1] ? (VAL_W'(0) - num.value) : num.value;
	assign slot_free = !out_valid_q || text.ready;

	always_comb begin
		ndig_c = IDX_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digs[i] = dbl_q.bcd[i*DIG_W +: DIG_W];
			if (digs[i] != '0) begin
				ndig_c = IDX_W'(i + 1);
			end
		end
	end

	always_comb begin
		load      = 1'b0;
		load_char = CHAR_MINUS;
		load_last = 1'b0;
		case (state_q)
			ST_SIGN: begin
				load = slot_free;
			end
			ST_EMIT: begin
				load      = slot_free;
				load_char = CHAR_ZERO + CHAR_W'(digs[idx_q[IDX_W-1:0]]);
				load_last = (idx_q == '0);
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CONV_CYCLES - 1)) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					state_q <= neg_q ? ST_SIGN : ST_EMIT;
				end
				ST_SIGN: begin
					if (load) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load && load_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= num.value[VAL_W-1];
			dbl_q   <= '{bcd: '0, bin: mag};
		end else if (state_q == ST_CONV) begin
			dbl_q   <= dbl_nxt;
		end
		if (state_q == ST_COUNT) begin
			ndig_q  <= ndig_c;
			idx_q   <= ndig_c - IDX_W'(1);
			total_q <= COUNT_W'(ndig_c) + COUNT_W'(neg_q);
		end else if (state_q == ST_EMIT && load) begin
			idx_q   <= idx_q - IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q  <= load_char;
			out_last_q  <= load_last;
			out_count_q <= total_q;
		end
	end

	assign text.valid      = out_valid_q;
	assign text.ascii_char = out_char_q;
	assign text.last_char  = out_last_q;
	assign text.char_count = out_count_q;

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == '0))
		else $error("accepted number did not start conversion");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q < ndig_q))
		else $error("digit index beyond digit count");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ascii_char == CHAR_MINUS) |-> !text.last_char)
		else $error("minus sign flagged as last character");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.char_count != '0))
		else $error("zero character count on output beat");

endmodule

@@ src/s2d_dabble.sv @@
// ----------------------------------------------------------------------------
// s2d_dabble
// Shift-and-add-3 unit: moves STEPS binary bits into the bcd digits per pass.
// ----------------------------------------------------------------------------
module s2d_dabble
	import s2d_pkg::*;
(
	input  dbl_t cur,
	output dbl_t nxt
);

	always_comb begin
		logic [BCD_W-1:0] bcd;
		logic [VAL_W-1:0] bin;
		logic [DIG_W-1:0] d;
		bcd = cur.bcd;
		bin = cur.bin;
		for (int s = 0; s < STEPS; s++) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				d = bcd[i*DIG_W +: DIG_W];
				if (d >= DIG_W'(5)) begin
					bcd[i*DIG_W +: DIG_W] = d + DIG_W'(3);
				end
			end
			bcd = {bcd[BCD_W-2:0], bin[VAL_W-1]};
			bin = {bin[VAL_W-2:0], 1'b0};
		end
		nxt.bcd = bcd;
		nxt.bin = bin;
	end

endmodule

@@ bench/signed_int_to_decimal_ascii_core_tb.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Self-checking bench for the signed integer to decimal text converter.
// Numbers go in on the num channel: first fixed values (zero, the extremes and
// every digit count of either sign), then random values that are spread over
// the digit counts. Each accepted number is turned into the characters it
// should print, and every text beat is checked field by field against the
// oldest character still waiting. The sender runs in bursts with gaps between
// them, and the receiver stalls in patterns that change over the run.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;
	import s2d_pkg::*;

	localparam int  DECIMAL_BASE = 10;
	localparam int  IDLE_LIMIT   = 5000;
	localparam int  TAIL_CYCLES  = 40;
	localparam int  RANDOM_ITEMS = 205;
	localparam longint MAX_POS   = 64'd2147483647;

	typedef struct packed {
		logic [CHAR_W-1:0]  ascii_char;
		logic               last_char;
		logic [COUNT_W-1:0] char_count;
	} text_beat_t;

	logic clk;
	logic arst_n;

	s2d_in_if  num_if ();
	s2d_out_if text_if ();

	signed_int_to_decimal_ascii_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.text   (text_if)
	);

	text_beat_t text_expected[$];
	int         mismatch_count;
	int         idle_cycles;
	int         burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// decimal text of one number, pushed in print order
	function automatic void predict_text(input logic [VAL_W-1:0] value);
		logic               negative;
		logic [VAL_W-1:0]   magnitude;
		logic [DIG_W-1:0]   digits [NUM_DIGITS];
		int                 ndig;
		logic [COUNT_W-1:0] total;
		text_beat_t         beat;
		negative  = value[VAL_W-1];
		magnitude = negative ? -value : value;
		ndig      = 0;
		do begin
			digits[ndig] = DIG_W'(magnitude % DECIMAL_BASE);
			magnitude    = magnitude / DECIMAL_BASE;
			ndig++;
		end while (magnitude != 0 && ndig < NUM_DIGITS);
		total = COUNT_W'(ndig + (negative ? 1 : 0));
		if (negative) begin
			beat = '{ascii_char: CHAR_MINUS, last_char: 1'b0, char_count: total};
			text_expected.push_back(beat);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			beat = '{ascii_char: CHAR_ZERO + CHAR_W'(digits[i]), last_char: (i == 0),
				char_count: total};
			text_expected.push_back(beat);
		end
	endfunction

	function automatic int next_burst();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_number(input logic [VAL_W-1:0] value);
		num_if.valid = 1'b1;
		num_if.value = value;
		do @(posedge clk); while (num_if.ready !== 1'b1);
		predict_text(value);
		@(negedge clk);
		num_if.valid = 1'b0;
		num_if.value = $urandom;
		burst_left--;
		if (burst_left <= 0) begin
			repeat ($urandom_range(1, 24)) @(negedge clk);
			burst_left = next_burst();
		end
	endtask

	task automatic wait_text_drained();
		while (text_expected.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		longint lo;
		longint hi;
		longint mag;
		int     len;
		case ($urandom_range(0, 9))
			0, 1: begin
				return $urandom;
			end
			2, 3, 4, 5, 6: begin
				len = $urandom_range(1, NUM_DIGITS);
				lo  = 1;
				repeat (len - 1) lo = lo * DECIMAL_BASE;
				hi  = lo * DECIMAL_BASE - 1;
				if (len == 1) lo = 0;
				if (hi > MAX_POS) hi = MAX_POS;
				mag = lo + longint'($urandom) % (hi - lo + 1);
				return $urandom_range(0, 1) ? VAL_W'(-mag) : VAL_W'(mag);
			end
			7: begin
				return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
					: 32'h7FFF_FFFF - $urandom_range(0, 15);
			end
			8: begin
				mag = longint'($urandom_range(0, 40));
				return VAL_W'(mag - 20);
			end
			default: begin
				mag = 1;
				repeat ($urandom_range(0, NUM_DIGITS - 1)) mag = mag * DECIMAL_BASE;
				return $urandom_range(0, 1) ? VAL_W'(-mag) : VAL_W'(mag);
			end
		endcase
	endfunction

	task automatic test_special_values();
		send_number(32'd0);
		send_number(32'd1);
		send_number(-32'sd1);
		send_number(32'd9);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'h8000_0001);
	endtask

	// 10^k and -(10^k - 1) for k from 1 to 9
	task automatic test_digit_boundaries();
		longint p;
		p = 1;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			p = p * DECIMAL_BASE;
			send_number(VAL_W'(p));
			send_number(VAL_W'(-(p - 1)));
		end
	endtask

	task automatic test_random_values();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) wait_text_drained();
			send_number(random_value());
		end
	endtask

	// receiver stall patterns
	initial begin
		int          mode;
		int          span;
		logic [7:0]  mask;
		text_if.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 128);
			mask = 8'($urandom_range(1, 255));
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				case (mode)
					0: text_if.ready = 1'b1;
					1: text_if.ready = ($urandom_range(0, 3) != 0);
					2: text_if.ready = mask[c % 8];
					default: text_if.ready = 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// beat checker and watchdog
	always @(posedge clk) begin
		text_beat_t want;
		logic       moved;
		moved = 1'b0;
		if (arst_n) begin
			if (num_if.valid && num_if.ready) moved = 1'b1;
			if (text_if.valid && text_if.ready) begin
				moved = 1'b1;
				if (text_expected.size() == 0) begin
					$display("%0t: unexpected beat char=%h last=%b count=%0d", $time,
						text_if.ascii_char, text_if.last_char, text_if.char_count);
					mismatch_count++;
				end else begin
					want = text_expected.pop_front();
					if (text_if.ascii_char !== want.ascii_char) begin
						$display("%0t: ascii_char expected %h actual %h", $time,
							want.ascii_char, text_if.ascii_char);
						mismatch_count++;
					end
					if (text_if.last_char !== want.last_char) begin
						$display("%0t: last_char expected %b actual %b", $time,
							want.last_char, text_if.last_char);
						mismatch_count++;
					end
					if (text_if.char_count !== want.char_count) begin
						$display("%0t: char_count expected %0d actual %0d", $time,
							want.char_count, text_if.char_count);
						mismatch_count++;
					end
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		idle_cycles    = 0;
		burst_left     = next_burst();
		num_if.valid   = 1'b0;
		num_if.value   = '0;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_special_values();
		test_digit_boundaries();
		wait_text_drained();
		test_random_values();
		wait_text_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && text_expected.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/s2d_pkg.sv
src/s2d_if.sv
src/s2d_dabble.sv
src/signed_int_to_decimal_ascii_core.sv
bench/signed_int_to_decimal_ascii_core_tb.sv
